/* src/scmd_pkg.sv */
// shared constants for the square cell minimum distance block
// no dependencies
package scmd_pkg;

    localparam int FIELD_W = 23;
    localparam int DIST_W  = 25;
    localparam int CASE_W  = 2;
    localparam int RAD_W   = 2 * DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CASE_W-1:0] CASE_SHARED = 2'd0;
    localparam logic [CASE_W-1:0] CASE_SPAN   = 2'd1;
    localparam logic [CASE_W-1:0] CASE_EUCLID = 2'd2;

endpackage

/* src/square_cell_min_distance.sv */
// top level of the square cell minimum distance pipeline
// depends on scmd_pkg
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------------------
//  input   | i_start, o_busy      | i_a_left i_a_bottom i_a_side i_b_left ...
//  result  | o_valid (one cycle)  | o_distance o_case_taken
//
// one item enters every cycle; o_busy is always low
// the pipeline is 4 geometry stages, one sum stage, 25 square root
// stages (one root bit each) and the output register
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the pipeline never holds
module square_cell_min_distance #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [scmd_pkg::FIELD_W-1:0]   i_a_left,
    input  logic [scmd_pkg::FIELD_W-1:0]   i_a_bottom,
    input  logic [scmd_pkg::FIELD_W-1:0]   i_a_side,
    input  logic [scmd_pkg::FIELD_W-1:0]   i_b_left,
    input  logic [scmd_pkg::FIELD_W-1:0]   i_b_bottom,
    input  logic [scmd_pkg::FIELD_W-1:0]   i_b_side,
    output logic                           o_valid,
    output logic [scmd_pkg::DIST_W-1:0]    o_distance,
    output logic [scmd_pkg::CASE_W-1:0]    o_case_taken
);
    import scmd_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int IW  = (FIELD_W > CW) ? FIELD_W : CW;
    localparam int MW  = (CW > DIST_W) ? CW : DIST_W;
    localparam int SW  = (2 * CW + 1 > RAD_W + 1) ? 2 * CW + 1 : RAD_W + 1;
    localparam int RW  = DIST_W + 2;

    typedef logic [CW-1:0] t_coord;

    function automatic t_coord fit(input logic [FIELD_W-1:0] v);
        logic [IW-1:0] e;
        begin
            e = IW'(v);
            fit = e[CW-1:0];
        end
    endfunction

    function automatic t_coord absd(input t_coord a, input t_coord b);
        absd = (a > b) ? a - b : b - a;
    endfunction

    function automatic t_coord min2(input t_coord a, input t_coord b);
        min2 = (a < b) ? a : b;
    endfunction

    function automatic logic in_span(input t_coord v, input t_coord lo, input t_coord hi);
        in_span = (v >= lo) && (v <= hi);
    endfunction

    assign o_busy = 1'b0;

    // stage 1: masked coordinates and far edges
    logic   r1_v;
    t_coord r1_ax0, r1_ay0, r1_ax1, r1_ay1, r1_bx0, r1_by0, r1_bx1, r1_by1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start;
        end
        r1_ax0 <= fit(i_a_left);
        r1_ay0 <= fit(i_a_bottom);
        r1_ax1 <= fit(i_a_left) + fit(i_a_side);
        r1_ay1 <= fit(i_a_bottom) + fit(i_a_side);
        r1_bx0 <= fit(i_b_left);
        r1_by0 <= fit(i_b_bottom);
        r1_bx1 <= fit(i_b_left) + fit(i_b_side);
        r1_by1 <= fit(i_b_bottom) + fit(i_b_side);
    end

    // stage 2: corner match, span hits and the edge differences
    // any x span hit brings in all four y differences and vice versa
    logic   r2_v, r2_shared, r2_xhit, r2_yhit;
    t_coord r2_dx [4];
    t_coord r2_dy [4];
    logic   n2_xeq, n2_yeq;

    always_comb begin
        n2_xeq = (r1_ax0 == r1_bx0) || (r1_ax0 == r1_bx1) ||
                 (r1_ax1 == r1_bx0) || (r1_ax1 == r1_bx1);
        n2_yeq = (r1_ay0 == r1_by0) || (r1_ay0 == r1_by1) ||
                 (r1_ay1 == r1_by0) || (r1_ay1 == r1_by1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_shared <= n2_xeq && n2_yeq;
        r2_xhit   <= in_span(r1_bx0, r1_ax0, r1_ax1) || in_span(r1_bx1, r1_ax0, r1_ax1) ||
                     in_span(r1_ax0, r1_bx0, r1_bx1) || in_span(r1_ax1, r1_bx0, r1_bx1);
        r2_yhit   <= in_span(r1_by0, r1_ay0, r1_ay1) || in_span(r1_by1, r1_ay0, r1_ay1) ||
                     in_span(r1_ay0, r1_by0, r1_by1) || in_span(r1_ay1, r1_by0, r1_by1);
        r2_dx[0]  <= absd(r1_ax0, r1_bx0);
        r2_dx[1]  <= absd(r1_ax0, r1_bx1);
        r2_dx[2]  <= absd(r1_ax1, r1_bx0);
        r2_dx[3]  <= absd(r1_ax1, r1_bx1);
        r2_dy[0]  <= absd(r1_ay0, r1_by0);
        r2_dy[1]  <= absd(r1_ay0, r1_by1);
        r2_dy[2]  <= absd(r1_ay1, r1_by0);
        r2_dy[3]  <= absd(r1_ay1, r1_by1);
    end

    // stage 3: least x and y difference
    logic   r3_v, r3_shared, r3_xhit, r3_yhit;
    t_coord r3_mdx, r3_mdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_shared <= r2_shared;
        r3_xhit   <= r2_xhit;
        r3_yhit   <= r2_yhit;
        r3_mdx    <= min2(min2(r2_dx[0], r2_dx[1]), min2(r2_dx[2], r2_dx[3]));
        r3_mdy    <= min2(min2(r2_dy[0], r2_dy[1]), min2(r2_dy[2], r2_dy[3]));
    end

    // stage 4: case decision and squares
    // least squared corner distance is the sum of the least squares per axis
    logic               r4_v;
    logic [CASE_W-1:0]  r4_case;
    logic [DIST_W-1:0]  r4_dist;
    logic [2*CW-1:0]    r4_sqx, r4_sqy;
    logic [CASE_W-1:0]  n4_case;
    logic [DIST_W-1:0]  n4_dist;
    t_coord             n4_best;

    always_comb begin
        n4_best = r3_mdx;
        if (r3_xhit && r3_yhit) begin
            n4_best = min2(r3_mdx, r3_mdy);
        end else if (r3_xhit) begin
            n4_best = r3_mdy;
        end
        n4_dist = (MW'(n4_best) > MW'(DIST_MAX)) ? DIST_MAX : DIST_W'(n4_best);
        if (r3_shared) begin
            n4_case = CASE_SHARED;
            n4_dist = '0;
        end else if (r3_xhit || r3_yhit) begin
            n4_case = CASE_SPAN;
        end else begin
            n4_case = CASE_EUCLID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_case <= n4_case;
        r4_dist <= n4_dist;
        r4_sqx  <= (2*CW)'(r3_mdx) * (2*CW)'(r3_mdy - r3_mdy + r3_mdx);
        r4_sqy  <= (2*CW)'(r3_mdy) * (2*CW)'(r3_mdy);
    end

    // stage 5: squared sum, saturating where the root cannot fit
    logic               r5_v, r5_sat;
    logic [CASE_W-1:0]  r5_case;
    logic [DIST_W-1:0]  r5_dist;
    logic [RAD_W-1:0]   r5_rad;
    logic [SW-1:0]      n5_sum;

    assign n5_sum = SW'(r4_sqx) + SW'(r4_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_case <= r4_case;
        r5_dist <= r4_dist;
        r5_sat  <= |n5_sum[SW-1:RAD_W];
        r5_rad  <= n5_sum[RAD_W-1:0];
    end

    // square root: one root bit per stage, two radicand bits shifted in
    logic               r_sv   [DIST_W+1];
    logic               r_ssat [DIST_W+1];
    logic [CASE_W-1:0]  r_scase[DIST_W+1];
    logic [DIST_W-1:0]  r_sdist[DIST_W+1];
    logic [RAD_W-1:0]   r_srad [DIST_W+1];
    logic [RW-1:0]      r_srem [DIST_W+1];
    logic [DIST_W-1:0]  r_sroot[DIST_W+1];

    always_comb begin
        r_sv[0]    = r5_v;
        r_ssat[0]  = r5_sat;
        r_scase[0] = r5_case;
        r_sdist[0] = r5_dist;
        r_srad[0]  = r5_rad;
        r_srem[0]  = '0;
        r_sroot[0] = '0;
    end

    for (genvar s = 0; s < DIST_W; s++) begin : g_root
        logic [RW+1:0] n_rem;
        logic [RW+1:0] n_trial;

        always_comb begin
            n_rem   = {r_srem[s], r_srad[s][RAD_W-1 -: 2]};
            n_trial = (RW+2)'({r_sroot[s], 2'b01});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else begin
                r_sv[s+1] <= r_sv[s];
            end
            r_ssat[s+1]  <= r_ssat[s];
            r_scase[s+1] <= r_scase[s];
            r_sdist[s+1] <= r_sdist[s];
            r_srad[s+1]  <= {r_srad[s][RAD_W-3:0], 2'b00};
            if (n_rem >= n_trial) begin
                r_srem[s+1]  <= RW'(n_rem - n_trial);
                r_sroot[s+1] <= {r_sroot[s][DIST_W-2:0], 1'b1};
            end else begin
                r_srem[s+1]  <= RW'(n_rem);
                r_sroot[s+1] <= {r_sroot[s][DIST_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_sv[DIST_W];
        end
        o_case_taken <= r_scase[DIST_W];
        if (r_scase[DIST_W] == CASE_EUCLID) begin
            o_distance <= r_ssat[DIST_W] ? DIST_MAX : r_sroot[DIST_W];
        end else begin
            o_distance <= r_sdist[DIST_W];
        end
    end

endmodule

/* sim/tb.sv */
// testbench for the square cell minimum distance pipeline
// depends on scmd_pkg and square_cell_min_distance; checks every result against a local predictor
module tb;
    import scmd_pkg::*;

    localparam int CB = 24;
    localparam int LATENCY = 31;

    typedef logic [FIELD_W-1:0] t_fld;
    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic [CASE_W-1:0] kind;
    } t_dist_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_fld i_a_left = '0, i_a_bottom = '0, i_a_side = '0;
    t_fld i_b_left = '0, i_b_bottom = '0, i_b_side = '0;
    logic o_busy, o_valid;
    logic [DIST_W-1:0] o_distance;
    logic [CASE_W-1:0] o_case_taken;

    t_dist_res expected_dist_q[$];
    int mismatches = 0;
    int unexpected = 0;
    int items_sent = 0;
    int results_seen = 0;
    int case_count[3] = '{0, 0, 0};
    bit quiet = 0;

    square_cell_min_distance #(.COORD_BITS(CB)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] adiff(logic [63:0] a, logic [63:0] b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_dist_res cell_distance(t_fld al, t_fld ab, t_fld as_, t_fld bl,
                                                t_fld bb, t_fld bs);
        logic [63:0] msk, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, best, d, sx, sy, sq;
        logic [63:0] acx[4], acy[4], bcx[4], bcy[4];
        bit shared, span;
        t_dist_res r;
        msk = (64'd1 << CB) - 1;
        ax0 = al & msk; ay0 = ab & msk;
        bx0 = bl & msk; by0 = bb & msk;
        ax1 = (ax0 + (as_ & msk)) & msk; ay1 = (ay0 + (as_ & msk)) & msk;
        bx1 = (bx0 + (bs & msk)) & msk; by1 = (by0 + (bs & msk)) & msk;
        acx = '{ax0, ax1, ax0, ax1}; acy = '{ay0, ay0, ay1, ay1};
        bcx = '{bx0, bx1, bx0, bx1}; bcy = '{by0, by0, by1, by1};
        best = '1; shared = 0; span = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                if (acx[i] == bcx[j] && acy[i] == bcy[j]) shared = 1;
        if (shared) begin
            r.dval = '0; r.kind = CASE_SHARED;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            if (bcx[i] >= ax0 && bcx[i] <= ax1) begin
                span = 1;
                d = adiff(ay0, bcy[i]); if (d < best) best = d;
                d = adiff(ay1, bcy[i]); if (d < best) best = d;
            end
            if (acx[i] >= bx0 && acx[i] <= bx1) begin
                span = 1;
                d = adiff(by0, acy[i]); if (d < best) best = d;
                d = adiff(by1, acy[i]); if (d < best) best = d;
            end
            if (bcy[i] >= ay0 && bcy[i] <= ay1) begin
                span = 1;
                d = adiff(ax0, bcx[i]); if (d < best) best = d;
                d = adiff(ax1, bcx[i]); if (d < best) best = d;
            end
            if (acy[i] >= by0 && acy[i] <= by1) begin
                span = 1;
                d = adiff(bx0, acx[i]); if (d < best) best = d;
                d = adiff(bx1, acx[i]); if (d < best) best = d;
            end
        end
        if (span) begin
            r.dval = best > DIST_MAX ? DIST_MAX : best[DIST_W-1:0];
            r.kind = CASE_SPAN;
            return r;
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                sx = adiff(acx[i], bcx[j]); sx = sx * sx;
                sy = adiff(acy[i], bcy[j]); sy = sy * sy;
                sq = (sx > ~64'd0 - sy) ? ~64'd0 : sx + sy;
                if (sq < best) best = sq;
            end
        best = floor_root(best);
        r.dval = best > DIST_MAX ? DIST_MAX : best[DIST_W-1:0];
        r.kind = CASE_EUCLID;
        return r;
    endfunction

    // send one item, with an optional random gap before it
    task automatic send_cells(t_fld al, t_fld ab, t_fld as_, t_fld bl, t_fld bb, t_fld bs);
        if (!quiet) begin
            while ($urandom_range(99) < 30) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_a_left <= al; i_a_bottom <= ab; i_a_side <= as_;
        i_b_left <= bl; i_b_bottom <= bb; i_b_side <= bs;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_dist_q = {expected_dist_q, cell_distance(al, ab, as_, bl, bb, bs)};
        items_sent++;
    endtask

    task automatic go_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_dist_res e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_dist_q.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", o_distance);
            end else begin
                e = expected_dist_q.pop_front();
                if (e.kind < 3) case_count[e.kind]++;
                if (o_distance !== e.dval || o_case_taken !== e.kind) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: distance exp %0d got %0d, case exp %0d got %0d",
                                 e.dval, o_distance, e.kind, o_case_taken);
                end
            end
        end
    end

    function automatic t_fld rnd_field();
        case ($urandom_range(3))
            0: return t_fld'($urandom_range(15));
            1: return t_fld'('1 - $urandom_range(15));
            default: return t_fld'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        t_fld mx;
        mx = '1;
        send_cells(0, 0, 0, 0, 0, 0);
        send_cells(mx, mx, mx, mx, mx, mx);
        send_cells(0, 0, 0, mx, mx, mx);
        send_cells(mx, mx, 0, 0, 0, 0);
        send_cells(0, mx, mx, mx, 0, mx);
        send_cells(mx, 0, 1, 0, mx, 1);
        send_cells(23'h555555, 23'h2aaaaa, 23'h555555, 23'h2aaaaa, 23'h555555, 23'h2aaaaa);
    endtask

    task automatic test_shared_corner();
        send_cells(10, 10, 5, 15, 15, 3);
        send_cells(10, 10, 5, 5, 5, 5);
        send_cells(10, 10, 5, 15, 7, 3);
        send_cells(100, 100, 0, 100, 100, 50);
    endtask

    task automatic test_span();
        send_cells(10, 10, 10, 12, 30, 4);
        send_cells(10, 10, 10, 30, 12, 4);
        // overlapping but no shared corner
        send_cells(0, 0, 100, 20, 30, 10);
        send_cells(20, 30, 10, 0, 0, 100);
        send_cells(0, 0, 10, 10, 40, 5);
    endtask

    task automatic test_euclid();
        send_cells(0, 0, 3, 6, 7, 2);
        send_cells(100, 100, 1, 0, 0, 1);
        send_cells(0, 0, 0, 23'h7fffff, 23'h7fffff, 0);
        send_cells(50, 0, 5, 0, 60, 5);
    endtask

    task automatic test_random();
        t_fld al, ab, as_, bl, bb, bs;
        for (int n = 0; n < 850; n++) begin
            quiet = (n >= 300 && n < 450);
            case ($urandom_range(3))
                0: begin
                    al = rnd_field(); ab = rnd_field(); as_ = rnd_field();
                    bl = rnd_field(); bb = rnd_field(); bs = rnd_field();
                end
                1: begin
                    // nearby small cells, all three cases likely
                    al = t_fld'($urandom_range(64)); ab = t_fld'($urandom_range(64));
                    as_ = t_fld'($urandom_range(16));
                    bl = t_fld'($urandom_range(64)); bb = t_fld'($urandom_range(64));
                    bs = t_fld'($urandom_range(16));
                end
                2: begin
                    // touching along a corner
                    al = t_fld'($urandom_range(1000)); ab = t_fld'($urandom_range(1000));
                    as_ = t_fld'($urandom_range(200)); bs = t_fld'($urandom_range(200));
                    bl = al + as_; bb = $urandom_range(1) ? ab + as_ : ab - bs;
                end
                default: begin
                    al = t_fld'($urandom); ab = t_fld'($urandom);
                    as_ = t_fld'($urandom_range(4095));
                    bl = t_fld'($urandom); bb = t_fld'($urandom);
                    bs = t_fld'($urandom_range(4095));
                end
            endcase
            send_cells(al, ab, as_, bl, bb, bs);
        end
        quiet = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_shared_corner();
        test_span();
        test_euclid();
        test_random();
        go_idle();
        while (expected_dist_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("covered %0d items: %0d shared corner, %0d span, %0d euclidean",
                 items_sent, case_count[0], case_count[1], case_count[2]);
        if (mismatches == 0 && unexpected == 0 && expected_dist_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("timed out");
        $display("tb: failure");
        $finish;
    end
endmodule

/* square_cell_min_distance.f */
src/scmd_pkg.sv
src/square_cell_min_distance.sv
sim/tb.sv
